// ----- rtl/maf_pkg.sv -----
// maf_pkg: shared constants and types for the boxcar moving average filter
// fixed field widths, register map codes and register reset values
// no dependencies

package maf_pkg;

  // fixed port widths
  localparam int SAMPLE_PORT_W = 32;
  localparam int AVG_W         = 33;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int WIN_W         = 7;

  // register word index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  // register reset values
  localparam logic [WIN_W-1:0] WIN_RESET    = 7'd64;
  localparam logic             SIGNED_RESET = 1'b1;

  typedef logic [AVG_W-1:0]      avg_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

endpackage

// ----- rtl/moving_average_filter.sv -----
// moving_average_filter: boxcar moving average over a circular sample memory
// depends on maf_pkg for widths, register map and reset values

// One sample is accepted per item and one average is returned for it. The last
// window_length samples sit in a single-port synchronous memory that is read
// and written at the same entry in the accept cycle (old data comes back), and
// a running sum is updated from the new and the leaving sample. The average is
// the sum divided by the window length, truncated toward zero, computed by a
// restoring divider that resolves one quotient bit per cycle. No new sample
// is accepted, in_stall being high, until the divider has finished and the
// average has moved on into the output register, which frees the block. A
// finished average waits in the output register, so the next sample can be
// accepted while it is still stalled. Entries not yet written since reset or
// the last register write read as zero: a wrap flag marks when every position
// of the window holds a written sample, so no clearing pass is needed. A write
// to either register clears the window, the position and the sum. Registers:
// window_length at byte 0 (0 acts as 1, above DEPTH acts as DEPTH),
// samples_signed at byte 4; decode uses paddr[2] only.

module moving_average_filter #(
  parameter int DEPTH        = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [maf_pkg::SAMPLE_PORT_W-1:0]   in_sample,
  // average output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output maf_pkg::avg_t                       out_average,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [maf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  maf_pkg::cfg_data_t                  pwdata,
  output maf_pkg::cfg_data_t                  prdata,
  output logic                                pready
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int CW    = LW + 1;
  localparam int MAGW  = SW + $clog2(DEPTH);
  localparam int SUMW  = MAGW + 1;
  localparam int CNTW  = $clog2(MAGW + 1);
  localparam int XW    = (MAGW > maf_pkg::AVG_W) ? MAGW : maf_pkg::AVG_W;
  localparam int WIN_W = maf_pkg::WIN_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [WIN_W-1:0]  win_len_r;
  logic              samples_signed_r;
  logic [PW-1:0]     pos_r;
  logic              wrapped_r;
  logic              leave_valid_r;
  logic [SW-1:0]     fresh_r;
  logic [SW-1:0]     mem_rd_r;
  logic [SUMW-1:0]   sum_r;
  logic              neg_r;
  logic [MAGW-1:0]   quo_r;
  logic [LW-1:0]     rem_r;
  logic [CNTW-1:0]   cnt_r;
  logic              out_valid_r;
  maf_pkg::avg_t     out_average_r;

  logic [SW-1:0]     sample_mem [DEPTH];

  logic              in_accept;
  logic              out_free;
  logic              cfg_write;
  logic [LW-1:0]     eff_len;
  logic [CW-1:0]     pos_inc;
  logic              pos_wrap;
  logic [SUMW-1:0]   fresh_val;
  logic [SUMW-1:0]   leave_val;
  logic [CW-1:0]     rem_sh;
  logic              div_ge;
  logic [XW-1:0]     quo_ext;
  logic [XW-1:0]     avg_full;

  // handshakes
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      maf_pkg::REG_WINDOW: prdata = maf_pkg::CFG_DATA_W'(win_len_r);
      maf_pkg::REG_SIGNED: prdata = maf_pkg::CFG_DATA_W'(samples_signed_r);
      default:             prdata = '0;
    endcase
  end

  // effective window: zero acts as one, clamp to the memory depth
  always_comb begin
    if (win_len_r == '0) begin
      eff_len = LW'(1);
    end else if (32'(win_len_r) > DEPTH) begin
      eff_len = LW'(DEPTH);
    end else begin
      eff_len = LW'(win_len_r);
    end
  end

  // next write position
  assign pos_inc  = CW'(pos_r) + CW'(1);
  assign pos_wrap = (pos_inc >= CW'(eff_len));

  // sample interpretation, sign or zero extended to the sum width
  assign fresh_val = {{(SUMW-SW){samples_signed_r & fresh_r[SW-1]}}, fresh_r};
  assign leave_val = leave_valid_r ?
                     {{(SUMW-SW){samples_signed_r & mem_rd_r[SW-1]}}, mem_rd_r} : '0;

  // one restoring divide step
  assign rem_sh = {rem_r, quo_r[MAGW-1]};
  assign div_ge = (rem_sh >= CW'(eff_len));

  // signed quotient, truncated to the output width
  assign quo_ext  = XW'(quo_r);
  assign avg_full = neg_r ? (XW'(0) - quo_ext) : quo_ext;

  // sample memory: read-first, same entry read and written on accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rd_r          <= sample_mem[pos_r];
      sample_mem[pos_r] <= in_sample[SW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNTW'(MAGW - 1)) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state, window position and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      win_len_r        <= maf_pkg::WIN_RESET;
      samples_signed_r <= maf_pkg::SIGNED_RESET;
      pos_r            <= '0;
      wrapped_r        <= 1'b0;
      sum_r            <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) begin
        case (paddr[2])
          maf_pkg::REG_WINDOW: win_len_r        <= pwdata[WIN_W-1:0];
          maf_pkg::REG_SIGNED: samples_signed_r <= pwdata[0];
          default:             win_len_r        <= win_len_r;
        endcase
        pos_r     <= '0;
        wrapped_r <= 1'b0;
        sum_r     <= '0;
      end else begin
        if (in_accept) begin
          pos_r <= pos_wrap ? '0 : pos_inc[PW-1:0];
          if (pos_wrap) begin
            wrapped_r <= 1'b1;
          end
        end
        if (state_r == ST_SUM) begin
          sum_r <= sum_r + fresh_val - leave_val;
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fresh_r       <= in_sample[SW-1:0];
      leave_valid_r <= wrapped_r;
    end
    // magnitude and sign of the sum
    if (state_r == ST_ABS) begin
      neg_r <= sum_r[SUMW-1];
      quo_r <= sum_r[SUMW-1] ? MAGW'(SUMW'(0) - sum_r) : sum_r[MAGW-1:0];
      rem_r <= '0;
      cnt_r <= '0;
    end
    // one quotient bit per cycle
    if (state_r == ST_DIV) begin
      rem_r <= div_ge ? LW'(rem_sh - CW'(eff_len)) : LW'(rem_sh);
      quo_r <= {quo_r[MAGW-2:0], div_ge};
      cnt_r <= cnt_r + CNTW'(1);
    end
    if (state_r == ST_DONE && out_free) begin
      out_average_r <= avg_full[maf_pkg::AVG_W-1:0];
    end
  end

  // checks
  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(pos_r) < CW'(eff_len))
    else $error("write position outside the window");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (in_stall && state_r == ST_SUM))
    else $error("block not busy after accepting a beat");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < CNTW'(MAGW)))
    else $error("divider ran past its last step");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("finished average not presented");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench for the boxcar moving average filter
// depends on maf_pkg and moving_average_filter; predicts every average in-line

module tb;

  localparam int DEPTH    = 64;
  localparam int CLK_HALF = 4;

  logic                              clk         = 1'b0;
  logic                              rst_n       = 1'b0;
  logic                              in_valid    = 1'b0;
  logic                              in_stall;
  logic [maf_pkg::SAMPLE_PORT_W-1:0] in_sample   = '0;
  logic                              out_valid;
  logic                              out_stall   = 1'b0;
  maf_pkg::avg_t                     out_average;
  logic                              psel        = 1'b0;
  logic                              penable     = 1'b0;
  logic                              pwrite      = 1'b0;
  logic [maf_pkg::CFG_ADDR_W-1:0]    paddr       = '0;
  maf_pkg::cfg_data_t                pwdata      = '0;
  maf_pkg::cfg_data_t                prdata;
  logic                              pready;

  // shadow of the filter state and registers
  logic [maf_pkg::SAMPLE_PORT_W-1:0] model_mem [DEPTH];
  int unsigned                       model_pos;
  longint                            model_sum;
  logic [maf_pkg::WIN_W-1:0]         model_window;
  logic                              model_signed;
  maf_pkg::avg_t                     pending_averages [$];
  maf_pkg::avg_t                     head_avg;

  int error_count = 0;
  bit idle_on     = 1'b0;
  bit stall_on    = 1'b0;
  int stall_left  = 0;
  int next_stall;

  moving_average_filter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #CLK_HALF clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // sample mix: rails, sign boundary, small magnitudes and full random
  function automatic logic [maf_pkg::SAMPLE_PORT_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'(  $urandom_range(0, 255));
      5: return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned eff_window(input logic [maf_pkg::WIN_W-1:0] w);
    if (w == 0) return 1;
    if (w > DEPTH) return DEPTH;
    return w;
  endfunction

  function automatic longint as_value(input logic [maf_pkg::SAMPLE_PORT_W-1:0] b);
    if (model_signed) return longint'({{32{b[31]}}, b});
    return longint'({32'b0, b});
  endfunction

  function automatic void clear_model();
    foreach (model_mem[i]) model_mem[i] = '0;
    model_pos = 0;
    model_sum = 0;
  endfunction

  // replace the leaving entry, update the sum, divide toward zero
  function automatic maf_pkg::avg_t next_average(
    input logic [maf_pkg::SAMPLE_PORT_W-1:0] s
  );
    int unsigned len;
    int unsigned pos;
    longint      leaving;
    longint      quot;
    len = eff_window(model_window);
    pos = (model_pos >= len) ? 0 : model_pos;
    leaving = as_value(model_mem[pos]);
    model_mem[pos] = s;
    model_sum += as_value(s) - leaving;
    model_pos = (pos + 1 >= len) ? 0 : pos + 1;
    quot = model_sum / longint'(len);
    return maf_pkg::avg_t'(quot);
  endfunction

  // output stall pattern
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      next_stall = stall_on ? pick_gap() : 0;
      out_stall  <= (next_stall != 0);
      stall_left <= (next_stall > 0) ? next_stall - 1 : 0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_averages.size() == 0) begin
        error_count++;
        $error("average beat with none expected: got %0d", $signed(out_average));
      end else begin
        head_avg = pending_averages.pop_front();
        if (out_average !== head_avg) begin
          error_count++;
          $error("average mismatch: expected %0d, got %0d",
                 $signed(head_avg), $signed(out_average));
        end
      end
    end
  end

  // one sample beat, then an optional idle gap
  task automatic push_sample(input logic [maf_pkg::SAMPLE_PORT_W-1:0] s, input int gap);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    pending_averages.push_back(next_average(s));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  // register write then read-back, only with the filter idle
  task automatic write_register(input logic idx, input maf_pkg::cfg_data_t data);
    maf_pkg::cfg_data_t rd_want;
    drain_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == maf_pkg::REG_WINDOW) begin
      model_window = data[maf_pkg::WIN_W-1:0];
      rd_want      = maf_pkg::cfg_data_t'(data[maf_pkg::WIN_W-1:0]);
    end else begin
      model_signed = data[0];
      rd_want      = maf_pkg::cfg_data_t'(data[0]);
    end
    clear_model();
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== rd_want) begin
      error_count++;
      $error("prdata mismatch: expected %0h, got %0h", rd_want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // reset defaults: 64-sample signed window filling up from zeros
  task automatic test_reset_window();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    push_sample(32'h7FFF_FFFF, 0);
    push_sample(32'h8000_0000, 0);
    push_sample('1, 0);
    push_sample('0, 0);
    push_sample(32'h0000_0001, 0);
    push_sample(32'h1234_5678, 0);
    drain_results();
  endtask

  // window of one is a pass-through; zero length acts as one
  task automatic test_pass_through();
    write_register(maf_pkg::REG_WINDOW, 32'd1);
    write_register(maf_pkg::REG_SIGNED, 32'd0);
    push_sample('1, 0);
    push_sample('0, 0);
    push_sample(32'h8000_0000, 0);
    write_register(maf_pkg::REG_WINDOW, 32'd0);
    push_sample('1, 0);
    push_sample(32'h0000_0005, 0);
    drain_results();
  endtask

  // two-sample signed window: sign extremes and negative truncation
  task automatic test_short_window();
    write_register(maf_pkg::REG_WINDOW, 32'd2);
    write_register(maf_pkg::REG_SIGNED, 32'd1);
    push_sample(32'h8000_0000, 0);
    push_sample(32'h8000_0000, 0);
    push_sample(32'h7FFF_FFFF, 0);
    push_sample(32'hFFFF_FFFD, 0);
    push_sample('0, 0);
    drain_results();
  endtask

  // sender holds off until every average has come back, then resumes
  task automatic test_pause_until_empty();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    write_register(maf_pkg::REG_WINDOW, 32'd5);
    repeat (15) push_sample(pick_sample(), pick_gap());
    drain_results();
    repeat (15) push_sample(pick_sample(), pick_gap());
    drain_results();
  endtask

  // random streams over a sweep of window settings and sample modes
  task automatic test_random_phases();
    logic [maf_pkg::WIN_W-1:0] win_list [10] = '{7'd1, 7'd2, 7'd3, 7'd64, 7'd65,
                                                 7'd127, 7'd0, 7'd7, 7'd33, 7'd64};
    logic [maf_pkg::WIN_W-1:0] win;
    int                        n;
    for (int p = 0; p < 14; p++) begin
      win = (p < 10) ? win_list[p] : maf_pkg::WIN_W'($urandom_range(1, DEPTH));
      write_register(maf_pkg::REG_WINDOW,
                     {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, win});
      if (p == 0 || $urandom_range(0, 1))
        write_register(maf_pkg::REG_SIGNED,
                       {31'($urandom), 1'($urandom_range(0, 1))});
      idle_on  = (p % 4 != 3);
      stall_on = (p % 3 != 2);
      n = (eff_window(win) > 32) ? 120 : 45;
      repeat (n) push_sample(pick_sample(), idle_on ? pick_gap() : 0);
    end
    drain_results();
  endtask

  initial begin
    clear_model();
    model_window = maf_pkg::WIN_RESET;
    model_signed = maf_pkg::SIGNED_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_pass_through();
    test_short_window();
    test_pause_until_empty();
    test_random_phases();
    drain_results();
    stall_on = 1'b0;
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
